/* hdl/tar_pkg.sv */
// tensor axis reducer package: reduction mode codes, register indexes and count helpers
// no dependencies; imported by the reducer core

package tar_pkg;

  localparam int ACC_W     = 64;
  localparam int BEST_W    = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 17;

  localparam int MAX_INNER_DEF   = 1024;
  localparam int MAX_REDUCED_DEF = 65536;
  localparam int MAX_OUTER_DEF   = 65536;
  localparam int DATA_WIDTH_DEF  = 32;

  typedef enum logic [2:0] {
    MODE_SUM    = 3'd0,
    MODE_MIN    = 3'd1,
    MODE_MAX    = 3'd2,
    MODE_ARGMIN = 3'd3,
    MODE_ARGMAX = 3'd4,
    MODE_ANY    = 3'd5,
    MODE_ALL    = 3'd6
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 4'd0,
    REG_OUTER   = 4'd1,
    REG_REDUCED = 4'd2,
    REG_INNER   = 4'd3
  } cfg_reg_t;

  // last position index for a count register: zero acts as one, large values clamp
  function automatic logic [31:0] eff_last(input logic [31:0] v, input logic [31:0] cap);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd0;
    end else if (v > cap) begin
      r = cap - 32'd1;
    end else begin
      r = v - 32'd1;
    end
    return r;
  endfunction

endpackage

/* hdl/tar_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; used for the per-position accumulator store

module tar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/tensor_axis_reducer_core.sv */
// tensor axis reducer core: streaming reduction of a row-major array along one axis
// depends on tar_pkg and tar_ram
//
// usage:
//   elements enter on the in_ channel (valid/ready) in row-major order of an
//   outer x reduced x inner array; configure mode and the three counts first
//   through the cfg_ write port (a write to one of them restarts at position zero)
//   one request is taken per cycle while in_ready is high; the accumulator store
//   is read on acceptance, modified and written back when the update stage
//   advances, with forwarding when the next element hits the same inner position
//   each element of the last reduced slice produces one result on the out_
//   channel, via the update stage and the output register; out_last_of_array
//   marks the final result of the whole array, after which a new array begins
//   throughput: one element per cycle while no result stall holds it, set by
//   the single read-modify-write of the store per element
//   reset: positions return to zero, mode to sum and all counts to one; the
//   store is not cleared, since each entry is seeded by the first reduced slice
//   stall: a result waits in the output register; while it waits, the element
//   in the update stage holds if it also produces a result, and in_ready drops

module tensor_axis_reducer_core
  import tar_pkg::*;
#(
  parameter int MAX_INNER   = MAX_INNER_DEF,
  parameter int MAX_REDUCED = MAX_REDUCED_DEF,
  parameter int MAX_OUTER   = MAX_OUTER_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_element_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [ACC_W-1:0]      out_result_value,
  output logic [BEST_W-1:0]            out_result_index,
  output logic                         out_last_of_array
);

  localparam int IW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int RW = $clog2(MAX_REDUCED);
  localparam int OW = (MAX_OUTER > 1) ? $clog2(MAX_OUTER) : 1;
  localparam int SW = ACC_W + BEST_W;

  // configuration
  logic [2:0]  mode_r;
  logic [16:0] outer_r;
  logic [16:0] reduced_r;
  logic [10:0] inner_r;
  logic        cfg_hit;

  logic [31:0] ilast_w, rlast_w, olast_w;
  logic [IW-1:0] ilast;
  logic [RW-1:0] rlast;
  logic [OW-1:0] olast;

  // positions
  logic [IW-1:0] ip_r, ip_nxt;
  logic [RW-1:0] rp_r, rp_nxt;
  logic [OW-1:0] op_r, op_nxt;

  // update stage
  logic              s1_valid_r;
  logic [ACC_W-1:0]  s1_x_r;
  logic [IW-1:0]     s1_addr_r;
  logic              s1_seed_r;
  logic              s1_emit_r;
  logic              s1_last_r;
  logic [BEST_W-1:0] s1_pos_r;
  logic              fwd_hit_r;
  logic [SW-1:0]     fwd_data_r;

  logic              s0_acc;
  logic              s1_adv;
  logic [SW-1:0]     rd_data;
  logic [SW-1:0]     old_data;
  logic [ACC_W-1:0]  acc_old, acc_new;
  logic [BEST_W-1:0] best_old, best_new;
  logic              x_lt, x_gt, x_nz, acc_nz;
  logic              is_arg;

  // output register
  logic              out_valid_r;
  logic [ACC_W-1:0]  out_value_r;
  logic [BEST_W-1:0] out_index_r;
  logic              out_last_r;

  assign cfg_hit = cfg_we && (cfg_index == REG_MODE || cfg_index == REG_OUTER ||
                              cfg_index == REG_REDUCED || cfg_index == REG_INNER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_SUM;
      outer_r   <= 17'd1;
      reduced_r <= 17'd1;
      inner_r   <= 11'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:    mode_r    <= cfg_wdata[2:0];
        REG_OUTER:   outer_r   <= cfg_wdata;
        REG_REDUCED: reduced_r <= cfg_wdata;
        REG_INNER:   inner_r   <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  assign ilast_w = eff_last(32'(inner_r), 32'(MAX_INNER));
  assign rlast_w = eff_last(32'(reduced_r), 32'(MAX_REDUCED));
  assign olast_w = eff_last(32'(outer_r), 32'(MAX_OUTER));
  assign ilast   = ilast_w[IW-1:0];
  assign rlast   = rlast_w[RW-1:0];
  assign olast   = olast_w[OW-1:0];

  // handshake
  assign s1_adv   = s1_valid_r && (!s1_emit_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign s0_acc   = in_valid && in_ready;

  // position counters
  always_comb begin
    ip_nxt = ip_r;
    rp_nxt = rp_r;
    op_nxt = op_r;
    priority if (cfg_hit) begin
      ip_nxt = '0;
      rp_nxt = '0;
      op_nxt = '0;
    end else if (s0_acc) begin
      if (ip_r == ilast) begin
        ip_nxt = '0;
        if (rp_r == rlast) begin
          rp_nxt = '0;
          op_nxt = (op_r == olast) ? '0 : op_r + OW'(1);
        end else begin
          rp_nxt = rp_r + RW'(1);
        end
      end else begin
        ip_nxt = ip_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_r <= '0;
      rp_r <= '0;
      op_r <= '0;
    end else begin
      ip_r <= ip_nxt;
      rp_r <= rp_nxt;
      op_r <= op_nxt;
    end
  end

  // store: {best index, accumulator}
  tar_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_INNER),
    .AW    (IW)
  ) u_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr_r),
    .wdata ({best_new, acc_new}),
    .re    (s0_acc),
    .raddr (ip_r),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else if (s0_acc) begin
      s1_valid_r <= 1'b1;
      fwd_hit_r  <= s1_adv && (s1_addr_r == ip_r);
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_acc) begin
      s1_x_r     <= 64'(in_element_value);
      s1_addr_r  <= ip_r;
      s1_seed_r  <= (rp_r == '0);
      s1_emit_r  <= (rp_r == rlast);
      s1_last_r  <= (rp_r == rlast) && (ip_r == ilast) && (op_r == olast);
      s1_pos_r   <= BEST_W'(rp_r);
      fwd_data_r <= {best_new, acc_new};
    end
  end

  // read-modify-write
  assign old_data = fwd_hit_r ? fwd_data_r : rd_data;
  assign acc_old  = old_data[ACC_W-1:0];
  assign best_old = old_data[SW-1:ACC_W];
  assign x_lt     = $signed(s1_x_r) < $signed(acc_old);
  assign x_gt     = $signed(acc_old) < $signed(s1_x_r);
  assign x_nz     = (s1_x_r != '0);
  assign acc_nz   = (acc_old != '0);
  assign is_arg   = (mode_r == MODE_ARGMIN) || (mode_r == MODE_ARGMAX);

  always_comb begin
    acc_new  = acc_old;
    best_new = best_old;
    if (s1_seed_r) begin
      best_new = '0;
      acc_new  = (mode_r == MODE_ANY || mode_r == MODE_ALL) ? ACC_W'(x_nz) : s1_x_r;
    end else begin
      unique case (mode_r)
        MODE_MIN: begin
          if (x_lt) acc_new = s1_x_r;
        end
        MODE_MAX: begin
          if (x_gt) acc_new = s1_x_r;
        end
        MODE_ARGMIN: begin
          if (x_lt) begin
            acc_new  = s1_x_r;
            best_new = s1_pos_r;
          end
        end
        MODE_ARGMAX: begin
          if (x_gt) begin
            acc_new  = s1_x_r;
            best_new = s1_pos_r;
          end
        end
        MODE_ANY: acc_new = ACC_W'(acc_nz || x_nz);
        MODE_ALL: acc_new = ACC_W'(acc_nz && x_nz);
        default:  acc_new = acc_old + s1_x_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_value_r <= acc_new;
      out_index_r <= is_arg ? best_new : '0;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_result_value  = out_value_r;
  assign out_result_index  = out_index_r;
  assign out_last_of_array = out_last_r;

  // checks
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ip_r <= ilast) && (rp_r <= rlast) && (op_r <= olast))
    else $error("position counter beyond configured count");

  a_no_read_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !s0_acc)
    else $error("store read while update stage is stalled");

  a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_valid_r)
    else $error("forward flag set with empty update stage");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_addr_r) && $stable(s1_x_r)))
    else $error("stalled update stage lost its element");

endmodule

/* test/tensor_axis_reducer_checker.sv */
// checker for the tensor axis reducer: follows config writes and requests, predicts each result
// and compares it with what leaves the out_ channel; depends on tar_pkg

module tensor_axis_reducer_checker
  import tar_pkg::*;
#(
  parameter int MAX_INNER   = MAX_INNER_DEF,
  parameter int MAX_REDUCED = MAX_REDUCED_DEF,
  parameter int MAX_OUTER   = MAX_OUTER_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_element_value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ACC_W-1:0]      out_result_value,
  input  logic [BEST_W-1:0]     out_result_index,
  input  logic                  out_last_of_array,
  output int                    mismatches,
  output int                    outstanding,
  output int                    results_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic [BEST_W-1:0]       index;
    logic                    last;
  } reduction_t;

  reduction_t due_results[$];

  logic signed [ACC_W-1:0] partial_value [MAX_INNER];
  logic [31:0]             partial_best  [MAX_INNER];

  logic [2:0]  mode_reg;
  int unsigned outer_reg;
  int unsigned reduced_reg;
  int unsigned inner_reg;
  int unsigned inner_pos;
  int unsigned red_pos;
  int unsigned outer_pos;
  int          bad;
  int          seen;

  function automatic int unsigned span(input int unsigned v, input int unsigned cap);
    if (v == 0) return 1;
    return (v > cap) ? cap : v;
  endfunction

  task automatic fold_element(input logic [DATA_WIDTH-1:0] elem);
    int unsigned             ni;
    int unsigned             nr;
    int unsigned             no;
    int unsigned             slot;
    logic signed [DATA_WIDTH-1:0] narrow;
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] acc;
    logic [31:0]             best;
    reduction_t              r;
    ni = span(inner_reg, MAX_INNER);
    nr = span(reduced_reg, MAX_REDUCED);
    no = span(outer_reg, MAX_OUTER);
    slot = inner_pos % MAX_INNER;
    narrow = elem;
    x = ACC_W'(narrow);
    acc = partial_value[slot];
    best = partial_best[slot];
    if (red_pos == 0) begin
      if (mode_reg == MODE_ANY || mode_reg == MODE_ALL) acc = (x != 0) ? 64'sd1 : 64'sd0;
      else acc = x;
      best = 0;
    end else begin
      case (mode_reg)
        MODE_MIN: if (x < acc) acc = x;
        MODE_MAX: if (acc < x) acc = x;
        MODE_ARGMIN: if (x < acc) begin
          acc = x;
          best = red_pos;
        end
        MODE_ARGMAX: if (acc < x) begin
          acc = x;
          best = red_pos;
        end
        MODE_ANY: acc = (acc != 0 || x != 0) ? 64'sd1 : 64'sd0;
        MODE_ALL: acc = (acc != 0 && x != 0) ? 64'sd1 : 64'sd0;
        default: acc = acc + x;
      endcase
    end
    partial_value[slot] = acc;
    partial_best[slot] = best;

    if (red_pos + 1 >= nr) begin
      r.value = acc;
      r.index = (mode_reg == MODE_ARGMIN || mode_reg == MODE_ARGMAX) ? best[BEST_W-1:0] : '0;
      r.last = (inner_pos + 1 >= ni) && (outer_pos + 1 >= no);
      due_results = {due_results, r};
    end

    inner_pos++;
    if (inner_pos >= ni) begin
      inner_pos = 0;
      red_pos++;
      if (red_pos >= nr) begin
        red_pos = 0;
        outer_pos++;
        if (outer_pos >= no) outer_pos = 0;
      end
    end
  endtask

  always @(posedge clk) begin
    reduction_t want;
    if (!rst_n) begin
      mode_reg = MODE_SUM;
      outer_reg = 1;
      reduced_reg = 1;
      inner_reg = 1;
      inner_pos = 0;
      red_pos = 0;
      outer_pos = 0;
      due_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen++;
        if (due_results.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("result %0d: none due, got value %0d index %0d last %0b", seen,
                     $signed(out_result_value), out_result_index, out_last_of_array);
        end else begin
          want = due_results.pop_front();
          if (out_result_value !== want.value || out_result_index !== want.index ||
              out_last_of_array !== want.last) begin
            bad++;
            if (bad <= 10)
              $display("result %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       seen, want.value, want.index, want.last, $signed(out_result_value),
                       out_result_index, out_last_of_array);
          end
        end
      end
      if (in_valid && in_ready) fold_element(in_element_value);
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:    mode_reg = cfg_wdata[2:0];
          REG_OUTER:   outer_reg = 32'(cfg_wdata);
          REG_REDUCED: reduced_reg = 32'(cfg_wdata);
          REG_INNER:   inner_reg = 32'(cfg_wdata[10:0]);
          default: ;
        endcase
        // any real register write restarts the array
        if (cfg_index <= REG_INNER) begin
          inner_pos = 0;
          red_pos = 0;
          outer_pos = 0;
        end
      end
    end
    mismatches <= bad;
    outstanding <= due_results.size();
    results_seen <= seen;
  end

endmodule

/* test/tensor_axis_reducer_core_test.sv */
// top of the tensor axis reducer test: clock, reset, config writes, requests and result stalls
// depends on tar_pkg, tensor_axis_reducer_core and tensor_axis_reducer_checker

module tensor_axis_reducer_core_test
  import tar_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int                   ITEMS         = 1600;
  localparam int                   SETTLE_CYCLES = 6;
  localparam int                   HOLD_CYCLES   = 300;
  localparam int                   STALL_LIMIT   = 4000;
  localparam logic [2:0]           MODE_SPARE    = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 4'hf;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [31:0]          in_element_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [ACC_W-1:0]     out_result_value;
  logic [BEST_W-1:0]    out_result_index;
  logic                 out_last_of_array;

  int mismatches;
  int outstanding;
  int results_seen;
  int elements_sent = 0;
  int hold_asks = 0;
  int hold_served = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  tensor_axis_reducer_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_result_index  (out_result_index),
    .out_last_of_array (out_last_of_array)
  );

  tensor_axis_reducer_checker watch (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_value  (out_result_value),
    .out_result_index  (out_result_index),
    .out_last_of_array (out_last_of_array),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_seen      (results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[tensor_axis_reducer_core] ERROR");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] element_pick();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0: return 32'h0000_0000;
        1: return 32'h0000_0001;
        2: return 32'hffff_ffff;
        3: return 32'h7fff_ffff;
        default: return 32'h8000_0000;
      endcase
    end
    if (r < 4) return 32'($urandom_range(0, 6)) - 32'd3;
    return $urandom();
  endfunction

  task automatic send_element(input logic [31:0] v);
    int gap;
    in_valid <= 1'b1;
    in_element_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    elements_sent++;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pauses until every result is out and the pipeline is empty
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] m, input logic [CFG_W-1:0] outer_v,
                           input logic [CFG_W-1:0] reduced_v, input logic [CFG_W-1:0] inner_v,
                           input bit spare_write);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom());
    cfg_we <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_wdata <= ($urandom_range(0, 3) == 0) ? {junk[CFG_W-1:3], m} : {14'd0, m};
    @(posedge clk);
    cfg_index <= REG_OUTER;
    cfg_wdata <= outer_v;
    @(posedge clk);
    cfg_index <= REG_REDUCED;
    cfg_wdata <= reduced_v;
    @(posedge clk);
    cfg_index <= REG_INNER;
    cfg_wdata <= ($urandom_range(0, 3) == 0) ? {junk[CFG_W-1:11], inner_v[10:0]} : inner_v;
    @(posedge clk);
    if (spare_write) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= junk;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : receiver
    int n;
    @(posedge clk);
    forever begin
      if (hold_asks != hold_served) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served++;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
      repeat (n) begin
        @(posedge clk);
        if (hold_asks != hold_served) break;
      end
    end
  end

  initial begin : stimulus
    logic [31:0]      a;
    logic [31:0]      b;
    logic [2:0]       m;
    logic [CFG_W-1:0] oc;
    logic [CFG_W-1:0] rl;
    logic [CFG_W-1:0] ic;
    int               shape;
    int               burst;
    int               total;
    int               phase;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset configuration: every request is a whole array
    send_element(32'h7fff_ffff);
    send_element(32'h8000_0000);

    for (int k = MODE_SUM; k <= MODE_SPARE; k++) begin
      case (k)
        MODE_SUM:    begin a = 32'h7fff_ffff; b = 32'h7fff_ffff; end
        MODE_MIN:    begin a = 32'h8000_0000; b = 32'h0000_0000; end
        MODE_MAX:    begin a = 32'h0000_0000; b = 32'h7fff_ffff; end
        MODE_ARGMIN: begin a = 32'h0000_0005; b = 32'h0000_0005; end
        MODE_ARGMAX: begin a = 32'hffff_ffff; b = 32'hffff_ffff; end
        MODE_ANY:    begin a = 32'h0000_0000; b = 32'h0000_0000; end
        MODE_ALL:    begin a = 32'h0000_0001; b = 32'h8000_0000; end
        default:     begin a = 32'h8000_0000; b = 32'h8000_0000; end
      endcase
      settle_block();
      configure(k[2:0], 17'd1, 17'd2, 17'd1, 1'b0);
      send_element(a);
      send_element(b);
    end

    // oversized counts, left mid-array; then zero counts
    settle_block();
    configure(MODE_MAX, 17'h1ffff, 17'h1ffff, 17'd2047, 1'b0);
    send_element(32'h1234_5678);
    send_element(32'hedcb_a987);
    settle_block();
    configure(MODE_SUM, 17'd0, 17'd0, 17'd0, 1'b1);
    send_element(32'hffff_fffe);

    phase = 0;
    while (elements_sent < ITEMS || results_seen < 48) begin
      phase++;
      settle_block();
      m = 3'($urandom_range(MODE_SUM, MODE_SPARE));
      oc = 17'($urandom_range(1, 4));
      rl = 17'($urandom_range(1, 6));
      ic = 17'($urandom_range(1, 5));
      burst = 0;
      steady = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(0, 19);
      if (phase % 20 == 1) begin
        oc = 17'($urandom_range(8, 16));
        rl = 17'd1;
        ic = 17'($urandom_range(1, 4));
        burst = 60;
        steady = 1'b1;
      end else if (shape < 2) begin
        oc = 17'd1;
        ic = 17'd1;
        rl = 17'($urandom_range(1, 40));
      end else if (shape < 4) begin
        if ($urandom_range(0, 1)) oc = 17'd0;
        if ($urandom_range(0, 1)) rl = 17'd0;
        if ($urandom_range(0, 1)) ic = 17'd0;
      end else if (shape == 4) begin
        ic = $urandom_range(0, 1) ? 17'd1024 : 17'($urandom_range(1025, 2047));
        rl = 17'd1;
        oc = 17'd1;
        burst = $urandom_range(20, 60);
      end else if (shape == 5) begin
        rl = $urandom_range(0, 1) ? 17'd65536 : 17'($urandom_range(65537, 131071));
        burst = $urandom_range(10, 40);
      end else if (shape == 6) begin
        oc = $urandom_range(0, 1) ? 17'd65536 : 17'($urandom_range(65537, 131071));
        rl = 17'd1;
        ic = 17'd1;
        burst = $urandom_range(10, 40);
      end else if (shape == 7) begin
        oc = 17'd1;
        rl = 17'($urandom_range(20, 64));
        ic = 17'($urandom_range(1, 3));
      end
      configure(m, oc, rl, ic, $urandom_range(0, 9) == 0);
      if (phase % 20 == 1) hold_asks <= hold_asks + 1;
      if (burst > 0) begin
        total = burst;
      end else begin
        total = $urandom_range(1, 3) * ((oc == 0) ? 1 : oc) * ((rl == 0) ? 1 : rl) *
                ((ic == 0) ? 1 : ic);
        // a cut-short array is restarted by the next config write
        if ($urandom_range(0, 9) == 0) total = $urandom_range(1, total);
      end
      repeat (total) send_element(element_pick());
    end

    settle_block();
    if (mismatches == 0 && outstanding == 0) begin
      $display("[tensor_axis_reducer_core] OK");
    end else begin
      $display("[tensor_axis_reducer_core] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tar_pkg.sv
hdl/tar_ram.sv
hdl/tensor_axis_reducer_core.sv
test/tensor_axis_reducer_checker.sv
test/tensor_axis_reducer_core_test.sv
